@@ hdl/afft_pkg.sv @@
// Shared constants and types for the animation frame lookup block.
`default_nettype none
package afft_pkg;
    localparam int TIME_BITS  = 32;
    localparam int FRAME_BITS = 16;
    localparam int FT_BITS    = 24;
    localparam int FRAC_BITS  = 16;
    localparam int QUOT_BITS  = TIME_BITS + FT_BITS;
    localparam int COUNT_BITS = QUOT_BITS - FRAC_BITS;
    localparam int CFG_IDX_BITS = 3;

    localparam logic [FT_BITS-1:0]   FT_RESET = FT_BITS'(25600);
    localparam logic [FRAC_BITS:0]   FRAC_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_FRAME_TIME  = 3'd0,
        CFG_FIRST_FRAME = 3'd1,
        CFG_LAST_FRAME  = 3'd2,
        CFG_LOOPING     = 3'd3,
        CFG_FORCE_LOOP  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic pre;
        logic single;
    } div_tag_t;

    typedef struct packed {
        logic                  fin;
        logic                  use_mod;
        logic [FRAME_BITS-1:0] base;
        logic [FRAC_BITS:0]    fraction;
    } mod_tag_t;
endpackage
`default_nettype wire

@@ hdl/afft_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module afft_div import afft_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic [TIME_BITS-1:0] in_elapsed,
    input  wire logic [FT_BITS-1:0]   ft,
    input  wire div_tag_t             in_tag,
    output logic                      out_valid,
    output logic [QUOT_BITS-1:0]      out_quot,
    output div_tag_t                  out_tag
);
    logic                 v_s [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] w_s [0:QUOT_BITS];
    logic [FT_BITS-1:0]   r_s [0:QUOT_BITS];
    div_tag_t             t_s [0:QUOT_BITS];

    assign v_s[0] = in_valid;
    assign w_s[0] = {in_elapsed, {FT_BITS{1'b0}}};
    assign r_s[0] = '0;
    assign t_s[0] = in_tag;

    for (genvar k = 1; k <= QUOT_BITS; k++) begin : g_stage
        logic                 v_reg;
        logic [QUOT_BITS-1:0] w_reg, w_next;
        logic [FT_BITS-1:0]   r_reg, r_next;
        div_tag_t             t_reg;
        logic [FT_BITS:0]     trial, diff;
        logic                 ge;

        always_comb begin
            trial  = {r_s[k-1], w_s[k-1][QUOT_BITS-1]};
            diff   = trial - {1'b0, ft};
            ge     = trial >= {1'b0, ft};
            r_next = ge ? diff[FT_BITS-1:0] : trial[FT_BITS-1:0];
            w_next = {w_s[k-1][QUOT_BITS-2:0], ge};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_s[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                w_reg <= w_next;
                r_reg <= r_next;
                t_reg <= t_s[k-1];
            end
        end

        assign v_s[k] = v_reg;
        assign w_s[k] = w_reg;
        assign r_s[k] = r_reg;
        assign t_s[k] = t_reg;
    end

    assign out_valid = v_s[QUOT_BITS];
    assign out_quot  = w_s[QUOT_BITS];
    assign out_tag   = t_s[QUOT_BITS];
endmodule
`default_nettype wire

@@ hdl/afft_mod.sv @@
// Pipelined remainder unit for the loop wrap, one dividend bit per stage.
`default_nettype none
module afft_mod import afft_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [COUNT_BITS-1:0] in_x,
    input  wire logic [FRAME_BITS-1:0] len,
    input  wire mod_tag_t              in_tag,
    output logic                       out_valid,
    output logic [FRAME_BITS-1:0]      out_rem,
    output mod_tag_t                   out_tag
);
    logic                  v_s [0:COUNT_BITS];
    logic [COUNT_BITS-1:0] x_s [0:COUNT_BITS];
    logic [FRAME_BITS-1:0] r_s [0:COUNT_BITS];
    mod_tag_t              t_s [0:COUNT_BITS];

    assign v_s[0] = in_valid;
    assign x_s[0] = in_x;
    assign r_s[0] = '0;
    assign t_s[0] = in_tag;

    for (genvar k = 1; k <= COUNT_BITS; k++) begin : g_stage
        logic                  v_reg;
        logic [COUNT_BITS-1:0] x_reg, x_next;
        logic [FRAME_BITS-1:0] r_reg, r_next;
        mod_tag_t              t_reg;
        logic [FRAME_BITS:0]   trial, diff;

        always_comb begin
            trial  = {r_s[k-1], x_s[k-1][COUNT_BITS-1]};
            diff   = trial - {1'b0, len};
            r_next = (trial >= {1'b0, len}) ? diff[FRAME_BITS-1:0] : trial[FRAME_BITS-1:0];
            x_next = {x_s[k-1][COUNT_BITS-2:0], 1'b0};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (en) begin
                v_reg <= v_s[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg <= x_next;
                r_reg <= r_next;
                t_reg <= t_s[k-1];
            end
        end

        assign v_s[k] = v_reg;
        assign x_s[k] = x_reg;
        assign r_s[k] = r_reg;
        assign t_s[k] = t_reg;
    end

    assign out_valid = v_s[COUNT_BITS];
    assign out_rem   = r_s[COUNT_BITS];
    assign out_tag   = t_s[COUNT_BITS];
endmodule
`default_nettype wire

@@ hdl/animation_frame_for_time.sv @@
// Animation frame lookup: frame index and in-frame fraction for a time stamp.
// The pipeline is the bit-per-stage divider, a classify register, the
// bit-per-stage loop remainder unit and an output register.
// Throughput: one item per cycle; the whole pipeline holds while a result waits.
// Reset: synchronous active-low aresetn clears all valid bits and loads the
// register defaults (100 ms per frame, all frames 0, no looping).
`default_nettype none
module animation_frame_for_time import afft_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0] cfg_idx,
    input  wire logic [FT_BITS-1:0]      cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [TIME_BITS-1:0]    s_current_ms,
    input  wire logic [TIME_BITS-1:0]    s_start_ms,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [FRAME_BITS:0]   m_frame,
    output logic [FRAC_BITS:0]           m_fraction
);
    logic [FT_BITS-1:0]    frame_time_reg;
    logic [FRAME_BITS-1:0] first_reg, last_reg, looping_reg;
    logic                  force_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_time_reg <= FT_RESET;
            first_reg      <= '0;
            last_reg       <= '0;
            looping_reg    <= '0;
            force_reg      <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_idx))
                CFG_FRAME_TIME:  frame_time_reg <= cfg_wdata;
                CFG_FIRST_FRAME: first_reg      <= cfg_wdata[FRAME_BITS-1:0];
                CFG_LAST_FRAME:  last_reg       <= cfg_wdata[FRAME_BITS-1:0];
                CFG_LOOPING:     looping_reg    <= cfg_wdata[FRAME_BITS-1:0];
                CFG_FORCE_LOOP:  force_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // static per item: derived from config
    logic [FT_BITS-1:0]    ft_eff;
    logic [FRAME_BITS-1:0] span, l_len, start_cnt;
    always_comb begin
        ft_eff = (frame_time_reg == '0) ? FT_BITS'(1) : frame_time_reg;
        span   = (last_reg > first_reg) ? last_reg - first_reg : '0;
        l_len  = looping_reg;
        if (force_reg && looping_reg == '0) begin
            l_len = span;
        end
        if (l_len > span) begin
            l_len = span;
        end
        start_cnt = span - l_len;
    end

    div_tag_t             in_tag;
    logic [TIME_BITS-1:0] elapsed;
    always_comb begin
        elapsed       = s_current_ms - s_start_ms;
        in_tag.pre    = s_current_ms <= s_start_ms;
        in_tag.single = first_reg == last_reg;
    end

    logic                 d_valid;
    logic [QUOT_BITS-1:0] d_quot;
    div_tag_t             d_tag;

    afft_div u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .in_elapsed (elapsed),
        .ft         (ft_eff),
        .in_tag     (in_tag),
        .out_valid  (d_valid),
        .out_quot   (d_quot),
        .out_tag    (d_tag)
    );

    // classify the item and set up the wrap
    logic [COUNT_BITS-1:0] count, x_next;
    logic                  past;
    mod_tag_t              p_next;
    always_comb begin
        count  = d_quot[QUOT_BITS-1:FRAC_BITS];
        past   = (last_reg < first_reg) || (count > COUNT_BITS'(span));
        x_next = count - COUNT_BITS'(start_cnt);
        p_next.fin      = 1'b0;
        p_next.use_mod  = 1'b0;
        p_next.base     = first_reg;
        p_next.fraction = {1'b0, d_quot[FRAC_BITS-1:0]};
        priority if (d_tag.pre) begin
            p_next.fraction = '0;
        end else if (d_tag.single) begin
            p_next.fraction = FRAC_ONE;
        end else if (!past) begin
            p_next.base = first_reg + count[FRAME_BITS-1:0];
        end else begin
            p_next.fin     = l_len == '0;
            p_next.use_mod = 1'b1;
            p_next.base    = first_reg + start_cnt;
            if (l_len == FRAME_BITS'(1)) begin
                p_next.fraction = FRAC_ONE;
            end
        end
    end

    logic                  p_valid_reg;
    logic [COUNT_BITS-1:0] p_x_reg;
    mod_tag_t              p_tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (en) begin
            p_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_x_reg   <= x_next;
            p_tag_reg <= p_next;
        end
    end

    logic                  md_valid;
    logic [FRAME_BITS-1:0] md_rem;
    mod_tag_t              md_tag;

    afft_mod u_mod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (p_valid_reg),
        .in_x      (p_x_reg),
        .len       (l_len),
        .in_tag    (p_tag_reg),
        .out_valid (md_valid),
        .out_rem   (md_rem),
        .out_tag   (md_tag)
    );

    logic                  o_valid_reg;
    logic [FRAME_BITS:0]   o_frame_reg, o_frame_next;
    logic [FRAC_BITS:0]    o_frac_reg;
    logic [FRAME_BITS-1:0] sum;

    always_comb begin
        sum          = md_tag.base + (md_tag.use_mod ? md_rem : '0);
        o_frame_next = md_tag.fin ? '1 : {1'b0, sum};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
        end else if (en) begin
            o_valid_reg <= md_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            o_frame_reg <= o_frame_next;
            o_frac_reg  <= md_tag.fraction;
        end
    end

    assign m_valid    = o_valid_reg;
    assign m_frame    = o_frame_reg;
    assign m_fraction = o_frac_reg;
endmodule
`default_nettype wire
